### design/f2fq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2fq_pkg: shared types and constants
// Register indexes, field widths and the result record of the quantizer.
// ----------------------------------------------------------------------------
package f2fq_pkg;

    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_SCALE    = 1'b0;
    localparam logic [IDX_W-1:0] REG_SYM_MODE = 1'b1;

    localparam logic [7:0] SCALE_RST = 8'sd16;

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] value;
        logic        ovf;
        logic        unf;
        logic        asym;
        logic        batch_end;
    } result_t;

endpackage

### design/float_to_fixed_rne_quantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_fixed_rne_quantizer: scaled float to int32 quantizer
// Items pass an input and a result register; one per cycle when not stalled.
// ----------------------------------------------------------------------------
// One result per weight. Each item is taken into the input register, then
// into the result register once that is free or drains; one item per cycle
// is sustained while out_stall is low. An output stall holds the result
// register; the input stalls only once both registers hold items. A single
// conversion pass (shift, round, saturate) sits between the two registers.
module float_to_fixed_rne_quantizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [f2fq_pkg::IDX_W-1:0] cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] weight_bits,
    input  logic        batch_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] quantized_value,
    output logic        overflow_flag,
    output logic        underflow_flag,
    output logic        asymmetric_flag,
    output logic        batch_end_out
);

    logic [7:0]        scale_reg;
    logic              sym_reg;
    logic              s1_valid_reg;
    logic [31:0]       s1_weight_reg;
    logic              s1_be_reg;
    logic              out_valid_reg;
    f2fq_pkg::result_t out_reg;
    f2fq_pkg::result_t res_next;
    logic              advance;

    // stage 1 moves when the output register is free or drains
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= f2fq_pkg::SCALE_RST;
            sym_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                f2fq_pkg::REG_SCALE:    scale_reg <= cfg_data;
                f2fq_pkg::REG_SYM_MODE: sym_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // hold input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_weight_reg <= weight_bits;
            s1_be_reg     <= batch_end;
        end
    end

    f2fq_core u_core
    (
        .weight     (s1_weight_reg),
        .batch_end  (s1_be_reg),
        .pow2_shift (scale_reg),
        .sym_mode   (sym_reg),
        .res        (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
            out_reg <= res_next;
    end

    assign out_valid       = out_valid_reg;
    assign quantized_value = out_reg.value;
    assign overflow_flag   = out_reg.ovf;
    assign underflow_flag  = out_reg.unf;
    assign asymmetric_flag = out_reg.asym;
    assign batch_end_out   = out_reg.batch_end;

`ifndef SYNTH
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $countones({out_reg.ovf, out_reg.unf, out_reg.asym}) <= 1)
        else $error("more than one result flag set");
    a_ovf_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ovf) |-> out_reg.value == f2fq_pkg::POS_LIMIT)
        else $error("overflow without positive limit");
    a_asym_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.asym) |-> out_reg.value == 32'd0)
        else $error("rejected item with nonzero value");
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg && $stable(s1_weight_reg))
        else $error("input register lost while stalled");
`endif

endmodule

### design/f2fq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2fq_core: combinational conversion
// Decodes one float, scales by a power of two, rounds half to even, saturates.
// ----------------------------------------------------------------------------
module f2fq_core
(
    input  logic [31:0]          weight,
    input  logic                 batch_end,
    input  logic [7:0]           pow2_shift,
    input  logic                 sym_mode,
    output f2fq_pkg::result_t    res
);

    logic        neg;
    logic [7:0]  ex;
    logic [23:0] man;
    logic signed [10:0] t;
    logic [5:0]  n;
    logic [32:0] mag;
    logic [54:0] shl;
    logic [23:0] q;
    logic [23:0] rem_mask;
    logic [23:0] rem;
    logic [23:0] half;
    logic        is_nan;
    logic        is_inf;

    // decode fields and effective exponent
    always_comb
    begin
        neg    = weight[31];
        ex     = weight[30:23];
        man    = {(ex != 8'd0), weight[22:0]};
        is_nan = (ex == 8'hFF) && (weight[22:0] != 23'd0);
        is_inf = (ex == 8'hFF) && (weight[22:0] == 23'd0);
        if (ex == 8'd0)
            t = 11'sd1 - 11'sd150 + 11'(signed'(pow2_shift));
        else
            t = signed'({3'd0, ex}) - 11'sd150 + 11'(signed'(pow2_shift));
        n = (t < 0) ? ((-t >= 11'sd25) ? 6'd25 : 6'((-t))) : 6'd0;
    end

    // shift and round
    always_comb
    begin
        q        = man >> n;
        rem_mask = (n >= 6'd24) ? 24'hFFFFFF : ((24'd1 << n) - 24'd1);
        rem      = man & rem_mask;
        half     = (n == 6'd0) ? 24'd0 : (24'd1 << (n - 6'd1));
        shl      = {31'd0, man} << t[4:0];
        mag      = 33'd0;
        if (t >= 0)
        begin
            // any bit past 32 means the value is far out of range
            if ((t >= 11'sd32) || (|shl[54:33]))
                mag = 33'h1_0000_0000;
            else
                mag = shl[32:0];
        end
        else if (n < 6'd25)
        begin
            if ((rem > half) || ((rem == half) && q[0]))
                mag = {9'd0, q} + 33'd1;
            else
                mag = {9'd0, q};
        end
    end

    // saturate and select special cases
    always_comb
    begin
        res           = '0;
        res.batch_end = batch_end;
        if (!sym_mode)
            res.asym = 1'b1;
        else if (is_nan)
            res.value = '0;
        else if (is_inf)
        begin
            res.value = neg ? f2fq_pkg::NEG_LIMIT : f2fq_pkg::POS_LIMIT;
            res.unf   = neg;
            res.ovf   = !neg;
        end
        else if (neg)
        begin
            if (mag > 33'h0_8000_0000)
            begin
                res.value = f2fq_pkg::NEG_LIMIT;
                res.unf   = 1'b1;
            end
            else
                res.value = 32'd0 - mag[31:0];
        end
        else
        begin
            if (mag > 33'h0_7FFF_FFFF)
            begin
                res.value = f2fq_pkg::POS_LIMIT;
                res.ovf   = 1'b1;
            end
            else
                res.value = mag[31:0];
        end
    end

endmodule

### bench/float_to_fixed_rne_quantizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_fixed_rne_quantizer_tb: self-checking bench for the quantizer
// Drives single-precision weights under several scale and mode settings,
// predicts each scaled, rounded and saturated result, and checks every
// output transfer in order, with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module float_to_fixed_rne_quantizer_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int NUM_PHASES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [f2fq_pkg::IDX_W-1:0] cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] weight_bits = '0;
    logic        batch_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] quantized_value;
    logic        overflow_flag;
    logic        underflow_flag;
    logic        asymmetric_flag;
    logic        batch_end_out;

    // Bench copy of the configuration registers
    logic [7:0] pow2_shift = f2fq_pkg::SCALE_RST;
    logic       sym_mode = 1'b1;

    f2fq_pkg::result_t pending_results[$];
    int      error_count = 0;
    int      checked_count = 0;
    int      sat_count = 0;
    int      reject_count = 0;
    int      cycle_count = 0;
    bit      no_idle = 1'b0;
    bit      start_hold = 1'b0;
    int      hold_left = 0;

    typedef struct {
        logic [31:0]       w;
        logic              be;
        bit                typed;
        f2fq_pkg::result_t res;
    } stim_row_t;

    stim_row_t directed_rows[$];

    float_to_fixed_rne_quantizer u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .weight_bits     (weight_bits),
        .batch_end       (batch_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .quantized_value (quantized_value),
        .overflow_flag   (overflow_flag),
        .underflow_flag  (underflow_flag),
        .asymmetric_flag (asymmetric_flag),
        .batch_end_out   (batch_end_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Scale by 2**pow2_shift, round half to even, saturate to int32
    function automatic f2fq_pkg::result_t quantize_weight(logic [31:0] bits, logic be);
        f2fq_pkg::result_t r;
        logic [7:0]  ex;
        logic [23:0] man;
        int          t;
        int          sexp;
        int          n;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        r = '0;
        r.batch_end = be;
        if (!sym_mode)
        begin
            r.asym = 1'b1;
            return r;
        end
        ex = bits[30:23];
        man = {1'b0, bits[22:0]};
        if (ex == 8'hFF)
        begin
            if (man != 0)
                return r;
            if (bits[31])
            begin
                r.value = f2fq_pkg::NEG_LIMIT;
                r.unf = 1'b1;
            end
            else
            begin
                r.value = f2fq_pkg::POS_LIMIT;
                r.ovf = 1'b1;
            end
            return r;
        end
        if (ex == 8'h00)
            t = -149;
        else
        begin
            man[23] = 1'b1;
            t = int'(ex) - 150;
        end
        if (man == 0)
            return r;
        sexp = $signed(pow2_shift);
        t = t + sexp;
        if (t >= 0)
            mag = (t >= 32) ? 64'h1_0000_0000 : (64'(man) << t);
        else
        begin
            n = -t;
            if (n >= 25)
                mag = 64'd0;
            else
            begin
                q = 64'(man) >> n;
                rem = 64'(man) & ((64'd1 << n) - 64'd1);
                half = 64'd1 << (n - 1);
                if (rem > half || (rem == half && q[0]))
                    q = q + 64'd1;
                mag = q;
            end
        end
        if (bits[31])
        begin
            if (mag > 64'h8000_0000)
            begin
                r.value = f2fq_pkg::NEG_LIMIT;
                r.unf = 1'b1;
            end
            else
                r.value = 32'd0 - mag[31:0];
        end
        else
        begin
            if (mag > 64'h7FFF_FFFF)
            begin
                r.value = f2fq_pkg::POS_LIMIT;
                r.ovf = 1'b1;
            end
            else
                r.value = mag[31:0];
        end
        return r;
    endfunction

    // Offer one weight, hold it until the transfer, then log its expectation
    task automatic send_weight(input logic [31:0] w, input logic be,
                               input bit typed, input f2fq_pkg::result_t tres);
        while (!no_idle && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        weight_bits <= w;
        batch_end <= be;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(typed ? tres : quantize_weight(w, be));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results(input int extra);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Write one register, then leave the write port idle before returning
    task automatic write_reg(input logic [f2fq_pkg::IDX_W-1:0] idx,
                             input logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == f2fq_pkg::REG_SCALE)
            pow2_shift = data;
        else
            sym_mode = data[0];
        @(posedge clk);
    endtask

    function automatic void add_row(logic [31:0] w, logic be, bit typed,
                                    logic [31:0] v, logic ovf, logic unf);
        stim_row_t s;
        s.w = w;
        s.be = be;
        s.typed = typed;
        s.res.value = v;
        s.res.ovf = ovf;
        s.res.unf = unf;
        s.res.asym = 1'b0;
        s.res.batch_end = be;
        directed_rows.push_back(s);
    endfunction

    // Random weight, mostly near the rounding and saturation boundaries
    function automatic logic [31:0] random_weight();
        logic [31:0] w;
        int          ex;
        int          n;
        int          sexp;
        sexp = $signed(pow2_shift);
        w = $urandom;
        case ($urandom_range(9))
            0, 1: ;
            2:
            begin
                case ($urandom_range(3))
                    0: w[30:0] = 31'h7F80_0000;
                    1: w[30:23] = 8'hFF;
                    2: w[30:0] = 31'd0;
                    default: w[30:23] = 8'h00;
                endcase
            end
            3, 4, 5:
            begin
                // tie or near-tie at the rounding point
                n = $urandom_range(24, 1);
                ex = 150 - sexp - n;
                if (ex >= 1 && ex <= 254)
                begin
                    w[30:23] = ex[7:0];
                    if ($urandom_range(1) == 0)
                        w[22:0] = (w[22:0] & ~((23'd1 << n) - 23'd1)) | (23'd1 << (n - 1));
                end
            end
            default:
            begin
                ex = 150 - sexp + $urandom_range(61) - 27;
                if (ex < 1)
                    ex = 1;
                if (ex > 254)
                    ex = 254;
                w[30:23] = ex[7:0];
            end
        endcase
        return w;
    endfunction

    // Check each output transfer and pick the next stall level
    always @(posedge clk)
    begin
        f2fq_pkg::result_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result expected none actual value=%h",
                             $time, quantized_value);
                    error_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    checked_count++;
                    if (e.ovf || e.unf)
                        sat_count++;
                    if (e.asym)
                        reject_count++;
                    if (quantized_value !== e.value)
                    begin
                        $display("%0t: quantized_value expected %h actual %h",
                                 $time, e.value, quantized_value);
                        error_count++;
                    end
                    if (overflow_flag !== e.ovf)
                    begin
                        $display("%0t: overflow_flag expected %b actual %b",
                                 $time, e.ovf, overflow_flag);
                        error_count++;
                    end
                    if (underflow_flag !== e.unf)
                    begin
                        $display("%0t: underflow_flag expected %b actual %b",
                                 $time, e.unf, underflow_flag);
                        error_count++;
                    end
                    if (asymmetric_flag !== e.asym)
                    begin
                        $display("%0t: asymmetric_flag expected %b actual %b",
                                 $time, e.asym, asymmetric_flag);
                        error_count++;
                    end
                    if (batch_end_out !== e.batch_end)
                    begin
                        $display("%0t: batch_end_out expected %b actual %b",
                                 $time, e.batch_end, batch_end_out);
                        error_count++;
                    end
                end
            end
            if (start_hold)
            begin
                start_hold = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !no_idle && ($urandom_range(99) < 35);
        end
    end

    initial
    begin
        int      p;
        int      i;
        logic [7:0] sc;
        f2fq_pkg::result_t none;
        none = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at the reset setting (scale 16, symmetric)
        add_row(32'h7F80_0000, 1'b0, 1, f2fq_pkg::POS_LIMIT, 1'b1, 1'b0);
        add_row(32'hFF80_0000, 1'b1, 1, f2fq_pkg::NEG_LIMIT, 1'b0, 1'b1);
        add_row(32'h7FC0_0001, 1'b0, 1, 32'd0, 1'b0, 1'b0);
        add_row(32'hFFFF_FFFF, 1'b1, 1, 32'd0, 1'b0, 1'b0);
        add_row(32'h0000_0000, 1'b0, 1, 32'd0, 1'b0, 1'b0);
        add_row(32'h8000_0000, 1'b1, 1, 32'd0, 1'b0, 1'b0);
        add_row(32'h0000_0001, 1'b0, 1, 32'd0, 1'b0, 1'b0);
        add_row(32'h807F_FFFF, 1'b0, 1, 32'd0, 1'b0, 1'b0);
        add_row(32'h3F80_0000, 1'b0, 1, 32'h0001_0000, 1'b0, 1'b0);
        add_row(32'hBF80_0000, 1'b1, 1, 32'hFFFF_0000, 1'b0, 1'b0);
        add_row(32'h7F7F_FFFF, 1'b0, 1, f2fq_pkg::POS_LIMIT, 1'b1, 1'b0);
        add_row(32'hFF7F_FFFF, 1'b1, 1, f2fq_pkg::NEG_LIMIT, 1'b0, 1'b1);
        add_row(32'hC700_0000, 1'b0, 1, f2fq_pkg::NEG_LIMIT, 1'b0, 1'b0);
        add_row(32'h4700_0000, 1'b0, 1, f2fq_pkg::POS_LIMIT, 1'b1, 1'b0);
        add_row(32'h3700_0000, 1'b0, 1, 32'd0, 1'b0, 1'b0);
        add_row(32'h37C0_0000, 1'b1, 1, 32'd2, 1'b0, 1'b0);
        add_row(32'h3820_0000, 1'b0, 1, 32'd2, 1'b0, 1'b0);
        add_row(32'h46FF_FFFF, 1'b1, 0, '0, 1'b0, 1'b0);
        add_row(32'hC6FF_FFFF, 1'b0, 0, '0, 1'b0, 1'b0);
        add_row(32'h3FC0_0001, 1'b1, 0, '0, 1'b0, 1'b0);
        foreach (directed_rows[k])
            send_weight(directed_rows[k].w, directed_rows[k].be,
                        directed_rows[k].typed, directed_rows[k].res);

        // Rejected items: symmetric mode off
        drain_results(4);
        write_reg(f2fq_pkg::REG_SYM_MODE, 8'hFE);
        none.asym = 1'b1;
        none.batch_end = 1'b1;
        send_weight(32'h7F80_0000, 1'b1, 1, none);
        none.batch_end = 1'b0;
        send_weight(32'h3F80_0000, 1'b0, 1, none);

        // Random phases, each under its own setting
        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain_results(4);
            case (p)
                0: sc = 8'h80;
                1: sc = 8'h7F;
                2: sc = 8'h00;
                3: sc = 8'hFF;
                4: sc = 8'd31;
                5: sc = 8'd30;
                default: sc = 8'($urandom_range(40)) - 8'd12;
            endcase
            write_reg(f2fq_pkg::REG_SCALE, sc);
            write_reg(f2fq_pkg::REG_SYM_MODE, {7'($urandom), (p != 3)});
            no_idle = (p == 5);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 6 && i == 20)
                    start_hold = 1'b1;
                if (p == 7 && i == 90)
                    drain_results(0);
                send_weight(random_weight(), 1'($urandom), 0, none);
            end
        end

        drain_results(10);
        no_idle = 1'b0;
        $display("Checked %0d results (%0d saturated, %0d rejected) over %0d settings",
                 checked_count, sat_count, reject_count, NUM_PHASES + 2);
        $display("Covered specials, ties to even, both scale extremes and long stalls");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
design/f2fq_pkg.sv
design/f2fq_core.sv
design/float_to_fixed_rne_quantizer.sv
bench/float_to_fixed_rne_quantizer_tb.sv
